// File: rtl/uewt_pkg.sv
package uewt_pkg;

   localparam int DEF_MAX_VERTICES = 64;

   localparam int VERTEX_W = 6;
   localparam int OP_W     = 2;
   localparam int VC_W     = 7;
   localparam int COUNT_W  = 11;

   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int REG_W    = CSR_AW - 2;

   localparam logic [REG_W-1:0] REG_VERTEX_COUNT = '0;
   localparam logic [VC_W-1:0]  VC_RESET         = 7'd64;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_WALK   = 2'd3;

endpackage

// File: rtl/uewt_row_mem.sv
module uewt_row_mem
   import uewt_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int AW = $clog2(MAX_VERTICES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [MAX_VERTICES-1:0] wr_data,
   input  logic [AW-1:0]           rd_addr,
   output logic [MAX_VERTICES-1:0] rd_row
);

   logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] rd_q_ff;

   // one flop per row: a row never written reads as empty
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic                    rd_valid_ff;

   // bypass for a read that meets a write to the same row at the same edge
   logic                    fwd_ff;
   logic [MAX_VERTICES-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows[wr_addr] <= wr_data;
      end
      rd_q_ff     <= rows[rd_addr];
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_row = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_row = rd_q_ff;
      end else begin
         rd_row = '0;
      end
   end

endmodule

// File: rtl/undirected_edge_table_walk_check.sv
// Undirected edge table with walk and path check.
//
// Requests enter on the req_ channel (valid/stall); each gives exactly one
// response on the rsp_ channel. A request is taken when req_valid is high and
// req_stall is low. Operations: add edge, remove edge, query edge, and walk
// vertex, which streams a vertex sequence marked first and last.
// vertex_count is written through the csr_ port at byte address 0. The user
// must write it only while the block is idle; the block does not enforce this.
//
// Every request passes through steps A and B: step A reads and rewrites row a
// of the adjacency memory (or reads the row of the previous walk vertex), step
// B reads and rewrites row b. The single memory port pair sets this sequence.
// The response is registered at the end of step B, and a new request can be
// accepted in step B of the previous one when rsp_stall holds no response.
// While rsp_stall holds a finished response, the block still takes the next
// request and parks it before its final step until the response drains.
// Reset empties the edge table at once (per-row valid flops), clears the
// edge count and walk state and sets vertex_count to 64.
module undirected_edge_table_walk_check
   import uewt_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [VERTEX_W-1:0] req_vertex_a,
   input  logic [VERTEX_W-1:0] req_vertex_b,
   input  logic                req_walk_first,
   input  logic                req_walk_last,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_success,
   output logic                rsp_range_error,
   output logic [COUNT_W-1:0]  rsp_edge_total,
   output logic                rsp_walk_done,
   output logic                rsp_is_walk_ok,
   output logic                rsp_is_path_ok,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int AW = $clog2(MAX_VERTICES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_A    = 2'd1;
   localparam logic [1:0] ST_B    = 2'd2;

   logic [1:0] state_ff, state_in;

   // configuration
   logic [VC_W-1:0] vertex_count_ff;
   logic            csr_sel_vc;

   assign csr_pready = 1'b1;
   assign csr_sel_vc = (csr_paddr[CSR_AW-1:2] == REG_VERTEX_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VC_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_vc) begin
         vertex_count_ff <= csr_pwdata[VC_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_sel_vc) begin
         csr_prdata = {{(CSR_DW-VC_W){1'b0}}, vertex_count_ff};
      end
   end

   // latched request
   logic [OP_W-1:0]     op_ff;
   logic [VERTEX_W-1:0] va_ff, vb_ff;
   logic                first_ff, last_ff;

   // walk state
   logic [VERTEX_W-1:0]     prev_ff;
   logic                    walk_good_ff, path_good_ff;
   logic [MAX_VERTICES-1:0] visited_ff;

   logic [COUNT_W-1:0] edge_count_ff, edge_count_in;

   // carried from the first step to the second
   logic upd_ff, add_ff;
   logic res_ok_ff, res_err_ff, res_done_ff, res_wv_ff, res_pv_ff;

   // memory interface
   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [MAX_VERTICES-1:0] wr_data, row;

   uewt_row_mem #(
      .MAX_VERTICES(MAX_VERTICES),
      .AW          (AW)
   ) u_row_mem (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_row (row)
   );

   logic accept, out_free, finish;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_B) && out_free));
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == ST_B) && out_free;

   // first-step decode
   logic [AW-1:0]           a_idx, b_idx;
   logic [MAX_VERTICES-1:0] mask_a, mask_b;
   logic                    a_ok, b_ok, err_a, present, pair_edge;
   logic                    do_add, do_rem, walk_op;
   logic                    wg_next, pg_next;

   assign a_idx  = AW'(va_ff);
   assign b_idx  = AW'(vb_ff);
   assign mask_a = MAX_VERTICES'(1) << a_idx;
   assign mask_b = MAX_VERTICES'(1) << b_idx;

   assign a_ok = ({1'b0, va_ff} < vertex_count_ff) && (32'(va_ff) < MAX_VERTICES);
   assign b_ok = ({1'b0, vb_ff} < vertex_count_ff) && (32'(vb_ff) < MAX_VERTICES);

   assign walk_op = (op_ff == OP_WALK);
   assign err_a   = walk_op ? !a_ok : !(a_ok && b_ok);

   assign present   = row[b_idx];
   assign pair_edge = row[a_idx];
   assign do_add    = !err_a && (op_ff == OP_ADD) && !present && (va_ff != vb_ff);
   assign do_rem    = !err_a && (op_ff == OP_REMOVE) && present;

   assign wg_next = first_ff ? 1'b1 : (walk_good_ff && pair_edge);
   assign pg_next = first_ff ? 1'b1 : (path_good_ff && pair_edge && !visited_ff[a_idx]);

   // memory addressing and write-back
   always_comb begin
      rd_addr = (req_operation == OP_WALK) ? AW'(prev_ff) : AW'(req_vertex_a);
      wr_en   = 1'b0;
      wr_addr = a_idx;
      wr_data = do_add ? (row | mask_b) : (row & ~mask_b);
      unique case (state_ff)
         ST_A: begin
            rd_addr = b_idx;
            wr_en   = do_add || do_rem;
         end
         ST_B: begin
            // hold the row b read while the response waits
            if (!out_free) begin
               rd_addr = b_idx;
            end
            wr_en   = upd_ff && out_free;
            wr_addr = b_idx;
            wr_data = add_ff ? (row | mask_a) : (row & ~mask_a);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      edge_count_in = edge_count_ff;
      if (upd_ff) begin
         edge_count_in = add_ff ? edge_count_ff + COUNT_W'(1) : edge_count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_A;
         ST_A:    state_in = ST_B;
         ST_B:    if (out_free) state_in = accept ? ST_A : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         va_ff    <= req_vertex_a;
         vb_ff    <= req_vertex_b;
         first_ff <= req_walk_first;
         last_ff  <= req_walk_last;
      end
      if (state_ff == ST_A) begin
         add_ff      <= do_add;
         res_ok_ff   <= do_add || do_rem || (!err_a && (op_ff == OP_QUERY) && present);
         res_err_ff  <= err_a;
         res_done_ff <= walk_op && !err_a && last_ff;
         res_wv_ff   <= walk_op && !err_a && last_ff && wg_next;
         res_pv_ff   <= walk_op && !err_a && last_ff && wg_next && pg_next;
      end
      if (finish) begin
         rsp_success     <= res_ok_ff;
         rsp_range_error <= res_err_ff;
         rsp_edge_total  <= edge_count_in;
         rsp_walk_done   <= res_done_ff;
         rsp_is_walk_ok  <= res_wv_ff;
         rsp_is_path_ok  <= res_pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         upd_ff        <= 1'b0;
         edge_count_ff <= '0;
         prev_ff       <= '0;
         walk_good_ff  <= 1'b1;
         path_good_ff  <= 1'b1;
         visited_ff    <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_A) begin
            upd_ff <= do_add || do_rem;
            // advance the walk; an out-of-range vertex leaves it untouched
            if (walk_op && !err_a) begin
               prev_ff      <= va_ff;
               walk_good_ff <= wg_next;
               path_good_ff <= pg_next;
               visited_ff   <= (first_ff ? '0 : visited_ff) | mask_a;
            end
         end
         if (finish) begin
            edge_count_ff <= edge_count_in;
            upd_ff        <= 1'b0;
            rsp_valid     <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

endmodule

// File: rtl/uewt_check.sv
module uewt_check
   import uewt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_success,
   input logic               rsp_range_error,
   input logic [COUNT_W-1:0] rsp_edge_total,
   input logic               rsp_walk_done,
   input logic               rsp_is_walk_ok,
   input logic               rsp_is_path_ok
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_edge_total) && $stable(rsp_success))
      else $error("stalled response changed");

   // each accepted request occupies the table, so req_stall follows every acceptance
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("requests accepted back to back");

   a_verdict_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_walk_done |-> !rsp_is_walk_ok && !rsp_is_path_ok)
      else $error("verdict without walk end");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> !rsp_success && !rsp_walk_done)
      else $error("range error with side effect");

   a_path_implies_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_path_ok |-> rsp_is_walk_ok)
      else $error("path verdict without walk verdict");

endmodule

bind undirected_edge_table_walk_check uewt_check u_uewt_check (.*);
